### hdl/assert_macros.svh
// Assertion macros shared by the decoder RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check sampled on the rising edge of clk, quiet while rst_n is low.
`define VPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check sampled on every rising edge of clk, reset included.
`define VPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/vpd_pkg.sv
// Types, codes and decode functions for the prefix-length varint decoder.
// No dependencies.
package vpd_pkg;

  localparam logic STATUS_COMPLETE  = 1'b0;
  localparam logic STATUS_TRUNCATED = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] decoded_value;
    logic [2:0]  encoded_length;
    logic        status;
    logic        buffer_done;
  } out_beat_t;

  // Registered input beat.
  typedef struct packed {
    logic     valid;
    in_beat_t beat;
  } in_q_t;

  // Result produced by the decode core for the beat it consumes.
  typedef struct packed {
    logic      valid;
    out_beat_t beat;
  } res_t;

  // Total bytes of a value, selected by its first byte.
  function automatic logic [2:0] length_of(input logic [7:0] b);
    logic [2:0] len;
    case (b) inside
      [8'h00:8'h7F]: len = 3'd1;
      [8'h80:8'hBF]: len = 3'd2;
      [8'hC0:8'hDF]: len = 3'd3;
      [8'hE0:8'hEF]: len = 3'd4;
      [8'hF0:8'hF7]: len = 3'd5;
      [8'hF8:8'hFB]: len = 3'd2;
      [8'hFC:8'hFD]: len = 3'd3;
      default:       len = 3'd4;
    endcase
    return len;
  endfunction

  // Mask and sign-style fill of the gathered bytes.
  function automatic logic [31:0] finish_value(input logic [7:0] b, input logic [31:0] bits);
    logic [31:0] v;
    case (b) inside
      [8'h00:8'h7F]: v = bits & 32'h0000_007F;
      [8'h80:8'hBF]: v = bits & 32'h0000_3FFF;
      [8'hC0:8'hDF]: v = bits & 32'h001F_FFFF;
      [8'hE0:8'hEF]: v = bits & 32'h0FFF_FFFF;
      [8'hF0:8'hF7]: v = bits;
      [8'hF8:8'hFB]: v = (bits & 32'h0000_03FF) | 32'hFFFF_FC00;
      [8'hFC:8'hFD]: v = (bits & 32'h0001_FFFF) | 32'hFFFE_0000;
      default:       v = (bits & 32'h00FF_FFFF) | 32'hFF00_0000;
    endcase
    return v;
  endfunction

endpackage

### hdl/vpd_if.sv
// Valid/ready channel interfaces for the decoder's byte input and result output.
// Depends on nothing but plain logic types.
interface vpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface vpd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] decoded_value;
  logic [2:0]  encoded_length;
  logic        status;
  logic        buffer_done;

  modport source (output valid, output decoded_value, output encoded_length,
                  output status, output buffer_done, input ready);
  modport sink   (input valid, input decoded_value, input encoded_length,
                  input status, input buffer_done, output ready);
endinterface

### hdl/vpd_in_stage.sv
// Input register: holds one accepted byte beat until the core consumes it.
// Depends on vpd_pkg and vpd_in_if.
module vpd_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  vpd_in_if.sink        in_chan,
  input  logic          fire,
  output vpd_pkg::in_q_t in_q
);

  logic              valid_r;
  logic              valid_nxt;
  vpd_pkg::in_beat_t beat_r;
  logic              take;

  assign in_chan.ready = !valid_r || fire;
  assign take          = in_chan.valid && in_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (fire) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      beat_r.data_byte     <= in_chan.data_byte;
      beat_r.end_of_buffer <= in_chan.end_of_buffer;
    end
  end

  assign in_q.valid = valid_r;
  assign in_q.beat  = beat_r;

endmodule

### hdl/vpd_core.sv
// Decode core: value state and the per-byte length, gather and finish logic.
// Depends on vpd_pkg.
module vpd_core (
  input  logic           clk,
  input  logic           rst_n,
  input  vpd_pkg::in_q_t in_q,
  input  logic           fire,
  output vpd_pkg::res_t  res
);

  logic [7:0]  first_byte_r,    first_byte_nxt;
  logic [2:0]  bytes_needed_r,  bytes_needed_nxt;
  logic [2:0]  bytes_seen_r,    bytes_seen_nxt;
  logic [31:0] gathered_bits_r, gathered_bits_nxt;

  logic        start;
  logic [7:0]  fb;
  logic [2:0]  need;
  logic [2:0]  seen;
  logic [31:0] gath;
  logic        done;
  logic        last;

  always_comb begin
    start = (bytes_needed_r == 3'd0);
    last  = in_q.beat.end_of_buffer;
    fb    = start ? in_q.beat.data_byte : first_byte_r;
    need  = start ? vpd_pkg::length_of(in_q.beat.data_byte) : bytes_needed_r;
    seen  = (start ? 3'd0 : bytes_seen_r) + 3'd1;
    gath  = {(start ? 24'd0 : gathered_bits_r[23:0]), in_q.beat.data_byte};
    done  = (seen >= need);

    res.valid = in_q.valid && (done || last);
    if (done) begin
      res.beat.decoded_value  = vpd_pkg::finish_value(fb, gath);
      res.beat.encoded_length = need;
      res.beat.status         = vpd_pkg::STATUS_COMPLETE;
    end else begin
      res.beat.decoded_value  = 32'd0;
      res.beat.encoded_length = seen;
      res.beat.status         = vpd_pkg::STATUS_TRUNCATED;
    end
    res.beat.buffer_done = last;

    // Any result returns the decoder to waiting for a first byte.
    if (done || last) begin
      first_byte_nxt    = 8'd0;
      bytes_needed_nxt  = 3'd0;
      bytes_seen_nxt    = 3'd0;
      gathered_bits_nxt = 32'd0;
    end else begin
      first_byte_nxt    = fb;
      bytes_needed_nxt  = need;
      bytes_seen_nxt    = seen;
      gathered_bits_nxt = gath;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_byte_r    <= 8'd0;
      bytes_needed_r  <= 3'd0;
      bytes_seen_r    <= 3'd0;
      gathered_bits_r <= 32'd0;
    end else if (fire) begin
      first_byte_r    <= first_byte_nxt;
      bytes_needed_r  <= bytes_needed_nxt;
      bytes_seen_r    <= bytes_seen_nxt;
      gathered_bits_r <= gathered_bits_nxt;
    end
  end

endmodule

### hdl/vpd_out_stage.sv
// Result register driving the output channel.
// Depends on vpd_pkg and vpd_out_if.
module vpd_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  vpd_pkg::res_t res,
  vpd_out_if.source     out_chan
);

  logic               valid_r;
  logic               valid_nxt;
  vpd_pkg::out_beat_t beat_r;
  logic               load;

  assign load = fire && res.valid;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat_r <= res.beat;
    end
  end

  assign out_chan.valid          = valid_r;
  assign out_chan.decoded_value  = beat_r.decoded_value;
  assign out_chan.encoded_length = beat_r.encoded_length;
  assign out_chan.status         = beat_r.status;
  assign out_chan.buffer_done    = beat_r.buffer_done;

endmodule

### hdl/varint_prefix_decoder_top.sv
// Prefix-length varint decoder, top level.
// Depends on vpd_pkg, vpd_if.sv, vpd_in_stage, vpd_core, vpd_out_stage, assert_macros.svh.
//
// Usage:
//  - in_chan carries one encoded byte per beat plus an end-of-buffer flag.
//  - out_chan carries one result per completed value (status complete) and one
//    per value cut short by the end-of-buffer flag (status truncated, value 0).
//    Mid-value bytes give no result.
//  - A byte accepted into the input register is decoded by the core, and its result, if
//    any, is loaded into the result register. Throughput: one byte per cycle while
//    out_chan.ready stays high; the input register and core then take a byte every cycle.
//  - The core consumes the registered byte whenever the result register is
//    empty or being emptied in the same cycle.
//  - When the receiver stalls, the result register holds its beat and the
//    input register holds one more byte; in_chan.ready then drops until
//    out_chan.ready returns.
//  - Reset (rst_n low, synchronous) empties both registers and returns the
//    decoder to waiting for a first byte.
`include "assert_macros.svh"

module varint_prefix_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  vpd_in_if.sink     in_chan,
  vpd_out_if.source  out_chan
);

  vpd_pkg::in_q_t in_q;
  vpd_pkg::res_t  res;
  logic           fire;

  // Core advances when a byte is waiting and the result slot is free or being emptied.
  assign fire = in_q.valid && (!out_chan.valid || out_chan.ready);

  vpd_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .fire    (fire),
    .in_q    (in_q)
  );

  vpd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .in_q  (in_q),
    .fire  (fire),
    .res   (res)
  );

  vpd_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .res      (res),
    .out_chan (out_chan)
  );

  // Result-side terms for the checks below.
  logic out_trunc;
  logic out_cmpl;
  logic trunc_ok;
  logic len_ok;

  assign out_trunc = out_chan.valid && (out_chan.status == vpd_pkg::STATUS_TRUNCATED);
  assign out_cmpl  = out_chan.valid && (out_chan.status == vpd_pkg::STATUS_COMPLETE);
  assign trunc_ok  = (out_chan.decoded_value == 32'd0) && out_chan.buffer_done &&
                     (out_chan.encoded_length >= 3'd1) && (out_chan.encoded_length <= 3'd4);
  assign len_ok    = (out_chan.encoded_length >= 3'd1) && (out_chan.encoded_length <= 3'd5);

  // Truncated results carry zero, a length of 1..4 and always close the buffer.
  `VPD_ASSERT(a_trunc_shape, out_trunc |-> trunc_ok, "truncated result malformed")

  // Completed values are 1..5 bytes long.
  `VPD_ASSERT(a_len_range, out_cmpl |-> len_ok, "complete length out of range")

  // A consumed byte that yields no result must not have ended the buffer.
  `VPD_ASSERT(a_eob_emits, (fire && !res.valid) |-> !in_q.beat.end_of_buffer, "end of buffer swallowed")

endmodule
